@@ rtl/cma_pkg.sv @@
package cma_pkg;

    localparam int MAX_WINDOW  = 32;
    localparam int SAMPLE_BITS = 16;
    localparam int WIN_W       = 6;
    localparam int WIN_RESET   = 4;
    localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_WINDOW);
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int SLOT_W      = $clog2(MAX_WINDOW);
    localparam int ITER_W      = $clog2(SUM_W + 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_real;
        logic signed [SAMPLE_BITS-1:0] sample_imag;
        logic                          end_of_signal;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean_real;
        logic signed [SAMPLE_BITS-1:0] mean_imag;
        logic                          final_result;
        logic                          too_short;
    } out_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } cplx_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] re;
        logic signed [SUM_W-1:0] im;
    } sum_pair_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

@@ rtl/cma_hist.sv @@
module cma_hist (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [cma_pkg::SLOT_W-1:0] rd_addr,
    output cma_pkg::cplx_t            rd_data,
    input  logic                      wr_en,
    input  logic [cma_pkg::SLOT_W-1:0] wr_addr,
    input  cma_pkg::cplx_t            wr_data
);
    import cma_pkg::*;

    cplx_t mem [MAX_WINDOW];
    cplx_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/cma_div.sv @@
module cma_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  cma_pkg::sum_pair_t         sums,
    input  logic [cma_pkg::CNT_W-1:0]  divisor,
    output cma_pkg::cplx_t             quot,
    output cma_pkg::div_status_t       status
);
    import cma_pkg::*;

    // two restoring lanes (real, imag) stepping under one counter
    logic [SUM_W-1:0]  dvd_reg  [2];
    logic [SUM_W-1:0]  dvd_next [2];
    logic [CNT_W-1:0]  rem_reg  [2];
    logic [CNT_W-1:0]  rem_next [2];
    logic              neg_reg  [2];
    logic [CNT_W:0]    trial    [2];
    logic [SUM_W-1:0]  mag_in   [2];
    logic signed [SUM_W-1:0] num [2];
    logic [SUM_W-1:0]  q_signed [2];
    logic [CNT_W-1:0]  divisor_reg;
    logic [ITER_W-1:0] cnt_reg;
    logic              done_reg;

    assign num[0] = sums.re;
    assign num[1] = sums.im;

    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            mag_in[i] = num[i][SUM_W-1] ? (~num[i] + 1'b1) : num[i];
            trial[i]  = {rem_reg[i], dvd_reg[i][SUM_W-1]};
            if (trial[i] >= {1'b0, divisor_reg})
            begin
                rem_next[i] = CNT_W'(trial[i] - {1'b0, divisor_reg});
                dvd_next[i] = {dvd_reg[i][SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[i] = trial[i][CNT_W-1:0];
                dvd_next[i] = {dvd_reg[i][SUM_W-2:0], 1'b0};
            end
            q_signed[i] = neg_reg[i] ? (~dvd_reg[i] + 1'b1) : dvd_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= ITER_W'(SUM_W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == ITER_W'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            divisor_reg <= divisor;
            for (int i = 0; i < 2; i++)
            begin
                dvd_reg[i] <= mag_in[i];
                rem_reg[i] <= '0;
                neg_reg[i] <= num[i][SUM_W-1];
            end
        end
        else if (cnt_reg != '0)
        begin
            for (int i = 0; i < 2; i++)
            begin
                dvd_reg[i] <= dvd_next[i];
                rem_reg[i] <= rem_next[i];
            end
        end
    end

    assign quot.re     = q_signed[0][SAMPLE_BITS-1:0];
    assign quot.im     = q_signed[1][SAMPLE_BITS-1:0];
    assign status.busy = (cnt_reg != '0);
    assign status.done = done_reg;

endmodule

@@ rtl/complex_moving_average_top.sv @@
// channel   | handshake                    | payload
// sample    | sample_valid / sample_stall  | sample (in_item_t)
// result    | result_valid / result_stall  | result (out_item_t)
// cfg       | cfg_valid / cfg_ready        | cfg_data (window length)
//
// a sample that fills or slides the window goes through accept, sum update, launch,
// 21 steps of the bit-serial divider (one quotient bit per cycle), done, emit
// a sample before the window is full goes through accept and sum update, then emit when it ends a too-short signal;
// the last sample of a signal with a full window emits window-length results, one per cycle while result_stall is low
// rst_n clears sums, counters, sequencer and window length (back to 4)
// result_stall holds the output register (and emit); samples are taken once idle
module complex_moving_average_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  cma_pkg::in_item_t             sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output cma_pkg::out_item_t            result,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cma_pkg::WIN_W-1:0]     cfg_data
);
    import cma_pkg::*;

    state_t            state_reg, state_next;
    logic [WIN_W-1:0]  window_reg;
    logic [CNT_W-1:0]  win_eff;
    logic signed [SUM_W-1:0] sum_re_reg, sum_re_next;
    logic signed [SUM_W-1:0] sum_im_reg, sum_im_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [CNT_W-1:0]  rep_reg;
    logic              short_reg;
    in_item_t          sample_reg;
    logic              result_valid_reg;
    out_item_t         result_reg;
    logic              full;
    logic              filled;
    logic              sample_accept;
    logic              cfg_write;
    logic              mem_wr_en;
    logic              div_start;
    logic              out_load;
    logic              last_emit;
    cplx_t             hist_data;
    cplx_t             wr_data;
    cplx_t             quot;
    div_status_t       div_status;
    sum_pair_t         sums;

    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = CNT_W'(1);
        end
        else if (int'(window_reg) > MAX_WINDOW)
        begin
            win_eff = CNT_W'(MAX_WINDOW);
        end
        else
        begin
            win_eff = CNT_W'(window_reg);
        end
    end

    assign full      = (fill_reg >= win_eff);
    // window complete once this sample is counted
    assign filled    = (fill_next >= win_eff);
    assign last_emit = (rep_reg == CNT_W'(1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (sample_accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (filled)
                begin
                    state_next = ST_START;
                end
                else if (sample_reg.end_of_signal)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_START:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && last_emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        sample_stall = 1'b1;
        cfg_ready    = 1'b0;
        mem_wr_en    = 1'b0;
        div_start    = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                cfg_ready    = 1'b1;
                sample_stall = cfg_valid;
            end
            ST_UPDATE:
            begin
                mem_wr_en = 1'b1;
            end
            ST_START:
            begin
                div_start = 1'b1;
            end
            ST_DIV:
            begin
                div_start = 1'b0;
            end
            ST_EMIT:
            begin
                out_load = !result_valid_reg || !result_stall;
            end
            default:
            begin
                sample_stall = 1'b1;
            end
        endcase
    end

    assign sample_accept = sample_valid && !sample_stall;
    assign cfg_write     = cfg_valid && cfg_ready;

    // window update: add new sample, drop the oldest once full
    always_comb
    begin
        sum_re_next = sum_re_reg + SUM_W'(sample_reg.sample_real);
        sum_im_next = sum_im_reg + SUM_W'(sample_reg.sample_imag);
        fill_next   = fill_reg;
        if (full)
        begin
            sum_re_next = sum_re_next - SUM_W'(hist_data.re);
            sum_im_next = sum_im_next - SUM_W'(hist_data.im);
        end
        else
        begin
            fill_next = fill_reg + 1'b1;
        end
        if (int'(slot_reg) + 1 >= int'(win_eff))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_reg       <= WIN_W'(WIN_RESET);
            sum_re_reg       <= '0;
            sum_im_reg       <= '0;
            fill_reg         <= '0;
            slot_reg         <= '0;
            rep_reg          <= '0;
            short_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                window_reg <= cfg_data;
                sum_re_reg <= '0;
                sum_im_reg <= '0;
                fill_reg   <= '0;
                slot_reg   <= '0;
            end
            else if (state_reg == ST_UPDATE)
            begin
                sum_re_reg <= sum_re_next;
                sum_im_reg <= sum_im_next;
                fill_reg   <= fill_next;
                slot_reg   <= slot_next;
                short_reg  <= !filled;
                if (filled && sample_reg.end_of_signal)
                begin
                    rep_reg <= win_eff;
                end
                else
                begin
                    rep_reg <= CNT_W'(1);
                end
            end
            else if (out_load)
            begin
                rep_reg <= rep_reg - 1'b1;
                // signal done: clear for the next one
                if (last_emit && sample_reg.end_of_signal)
                begin
                    sum_re_reg <= '0;
                    sum_im_reg <= '0;
                    fill_reg   <= '0;
                    slot_reg   <= '0;
                end
            end

            if (out_load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            sample_reg <= sample;
        end
        if (out_load)
        begin
            result_reg.too_short    <= short_reg;
            result_reg.final_result <= short_reg ||
                                       (last_emit && sample_reg.end_of_signal);
            result_reg.mean_real    <= short_reg ? '0 : quot.re;
            result_reg.mean_imag    <= short_reg ? '0 : quot.im;
        end
    end

    assign wr_data.re = sample_reg.sample_real;
    assign wr_data.im = sample_reg.sample_imag;

    cma_hist u_hist (
        .clk     (clk),
        .rd_en   (sample_accept),
        .rd_addr (slot_reg),
        .rd_data (hist_data),
        .wr_en   (mem_wr_en),
        .wr_addr (slot_reg),
        .wr_data (wr_data)
    );

    assign sums.re = sum_re_reg;
    assign sums.im = sum_im_reg;

    cma_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .sums    (sums),
        .divisor (win_eff),
        .quot    (quot),
        .status  (div_status)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= win_eff)
        else $error("fill count beyond window");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, slot_reg} < {1'b0, win_eff})
        else $error("write slot beyond window");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.done |-> state_reg == ST_DIV)
        else $error("divider finished outside wait state");

    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.too_short |->
            result.final_result && result.mean_real == '0 && result.mean_imag == '0)
        else $error("too-short result not final or nonzero");

    a_div_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        div_status.busy |-> sample_stall && !cfg_ready)
        else $error("input taken while divider busy");

endmodule

@@ verif/complex_moving_average_top_tb.sv @@
module complex_moving_average_top_tb;

    import cma_pkg::*;

    class mean_scoreboard;
        out_item_t   expected_means[$];
        logic [5:0]  window_reg;
        int          sum_re;
        int          sum_im;
        int          held;
        int          ring_pos;
        int          ring_re[MAX_WINDOW];
        int          ring_im[MAX_WINDOW];
        int          errors;

        function new();
            window_reg = WIN_W'(WIN_RESET);
            errors     = 0;
            clear_signal();
        endfunction

        function void clear_signal();
            sum_re   = 0;
            sum_im   = 0;
            held     = 0;
            ring_pos = 0;
        endfunction

        // a window write always drops the signal in progress
        function void set_window(logic [5:0] len);
            window_reg = len;
            clear_signal();
        endfunction

        function int active_window();
            if (window_reg == 0)
                return 1;
            if (window_reg > MAX_WINDOW)
                return MAX_WINDOW;
            return int'(window_reg);
        endfunction

        function int pending();
            return expected_means.size();
        endfunction

        function void note_sample(in_item_t s);
            int        w;
            int        idx;
            out_item_t m;
            w   = active_window();
            idx = ring_pos;
            if (held < w) begin
                sum_re += s.sample_real;
                sum_im += s.sample_imag;
                held++;
            end
            else begin
                sum_re += s.sample_real - ring_re[idx];
                sum_im += s.sample_imag - ring_im[idx];
            end
            ring_re[idx] = s.sample_real;
            ring_im[idx] = s.sample_imag;
            ring_pos = (idx + 1 >= w) ? 0 : idx + 1;

            if (held < w) begin
                // signal ended before the window filled
                if (s.end_of_signal) begin
                    m = '{mean_real: '0, mean_imag: '0, final_result: 1'b1, too_short: 1'b1};
                    expected_means.push_back(m);
                    clear_signal();
                end
                return;
            end

            m.mean_real    = sum_re / w;
            m.mean_imag    = sum_im / w;
            m.too_short    = 1'b0;
            m.final_result = 1'b0;
            if (!s.end_of_signal) begin
                expected_means.push_back(m);
                return;
            end
            // last sample: mean repeated to pad the output to the window length
            for (int k = 0; k < w; k++) begin
                m.final_result = (k == w - 1);
                expected_means.push_back(m);
            end
            clear_signal();
        endfunction

        function void check_mean(out_item_t got);
            out_item_t want;
            if (expected_means.size() == 0) begin
                errors++;
                if (errors <= 200)
                    $display("%0t: result with none expected: got re=%0d im=%0d %s",
                             $time, got.mean_real, got.mean_imag,
                             $sformatf("fin=%0b short=%0b", got.final_result,
                                       got.too_short));
                return;
            end
            want = expected_means.pop_front();
            if (got.mean_real !== want.mean_real || got.mean_imag !== want.mean_imag ||
                got.final_result !== want.final_result || got.too_short !== want.too_short)
            begin
                errors++;
                if (errors <= 200)
                    $display("%0t: mismatch: expected re=%0d im=%0d fin=%0b short=%0b, %s",
                             $time, want.mean_real, want.mean_imag, want.final_result,
                             want.too_short,
                             $sformatf("got re=%0d im=%0d fin=%0b short=%0b",
                                       got.mean_real, got.mean_imag, got.final_result,
                                       got.too_short));
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        sample_valid;
    logic        sample_stall;
    in_item_t    sample;
    logic        result_valid;
    logic        result_stall = 1'b1;
    out_item_t   result;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [WIN_W-1:0] cfg_data;

    mean_scoreboard sb;
    int             samples_sent = 0;
    int             results_seen = 0;
    int unsigned    hold_left = 0;
    bit             sender_quiet = 1'b0;
    bit             long_hold_req = 1'b0;
    bit             long_hold_done = 1'b0;

    complex_moving_average_top uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    // result side: random stall after each result, idle-free stretches, one long hold
    always @(posedge clk) begin
        int unsigned next_hold;
        if (!rst_n) begin
            hold_left    <= 0;
            result_stall <= 1'b1;
        end
        else begin
            next_hold = (hold_left > 0) ? hold_left - 1 : 0;
            if (result_valid && !result_stall) begin
                sb.check_mean(result);
                results_seen <= results_seen + 1;
                next_hold = ((results_seen / 48) % 3 == 2) ? 0 : $urandom_range(0, 9);
            end
            if (long_hold_req && !long_hold_done) begin
                next_hold = 400;
                long_hold_done <= 1'b1;
            end
            hold_left    <= next_hold;
            result_stall <= (next_hold != 0);
        end
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_part();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] re,
                               input logic signed [SAMPLE_BITS-1:0] im,
                               input logic last);
        int unsigned gap;
        in_item_t    req;
        gap = sender_quiet ? 0 : $urandom_range(0, 9);
        req = '{sample_real: re, sample_imag: im, end_of_signal: last};
        if (gap != 0) begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= req;
        @(posedge clk);
        while (sample_stall) @(posedge clk);
        sb.note_sample(req);
        samples_sent++;
    endtask

    task automatic send_signal(input int unsigned len, input bit terminated);
        for (int unsigned i = 0; i < len; i++)
            send_sample(pick_part(), pick_part(), terminated && (i == len - 1));
    endtask

    // stop offering and let every expected result come out, then let the block settle
    task automatic drain_results();
        sample_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] len);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_window(len);
    endtask

    initial begin
        logic [WIN_W-1:0] phase_windows [10];
        int               w;
        int               pick;
        int               phase_start;
        bit               paused;

        sb = new();
        phase_windows = '{6'd1, 6'd32, 6'd2, 6'd0, 6'd63, 6'd3, 6'd45, 6'd7, 6'd16, 6'd5};
        phase_windows[6] = WIN_W'($urandom_range(33, 63));
        phase_windows[8] = WIN_W'($urandom_range(1, 32));

        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of 4 out of reset
        send_sample(100, -100, 1'b1);
        send_sample(1, 2, 1'b0);
        send_sample(3, 4, 1'b0);
        send_sample(5, 6, 1'b1);
        repeat (4) send_sample(32767, -32768, 1'b0);
        send_sample(32767, -32768, 1'b1);
        // negative sums must truncate toward zero
        repeat (3) send_sample(-1, 1, 1'b0);
        send_sample(0, 0, 1'b1);
        // open signal, then a window write drops it
        send_sample(1000, -1000, 1'b0);
        send_sample(2000, -2000, 1'b0);
        drain_results();
        write_window(2);
        send_sample(-5, 7, 1'b0);
        send_sample(-6, 8, 1'b1);
        drain_results();
        write_window(0);
        send_sample(-32768, 32767, 1'b0);
        send_sample(5, -5, 1'b1);
        drain_results();
        write_window(63);
        send_sample(1, 1, 1'b1);

        for (int p = 0; p < 10; p++) begin
            drain_results();
            write_window(phase_windows[p]);
            sender_quiet = ($urandom_range(0, 3) == 0);
            // a long receiver hold stalls the result side while samples keep being offered
            if (p == 2)
                long_hold_req = 1'b1;
            phase_start = samples_sent;
            paused = 1'b0;
            while (samples_sent - phase_start < 30) begin
                w    = sb.active_window();
                pick = $urandom_range(0, 9);
                if (pick < 7)
                    send_signal($urandom_range(w, w + 8), 1'b1);
                else if (pick < 9)
                    send_signal((w > 1) ? $urandom_range(1, w - 1) : 1, 1'b1);
                else
                    send_signal($urandom_range(1, 2 * w + 4), 1'b0);
                if (p == 5 && !paused && samples_sent - phase_start >= 18) begin
                    drain_results();
                    paused = 1'b1;
                end
            end
        end

        drain_results();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #5000000;
        $display("Verification failed");
        $finish;
    end

endmodule
